[rtl/jsae_pkg.sv]
// jsae_pkg: shared widths, codes, character constants and the work word type
// for the json string array extractor.
// No dependencies; imported by every module of the block.
package jsae_pkg;

	// field widths
	localparam int BYTE_W     = 8;
	localparam int KIND_W     = 2;
	localparam int IDX_W      = 6;
	localparam int POS_W      = 5;
	localparam int CNT_W      = 7;
	localparam int STAT_W     = 2;
	localparam int KEY_LEN_W  = 5;
	localparam int KEY_WORD_W = 64;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// register reset values
	localparam logic [CNT_W-1:0] MAX_NAMES_RESET = 7'd64;

	// character constants
	localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
	localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5B;
	localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5D;
	localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
	localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
	localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
	localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
	localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_LENGTH = 2'd0,
		CFG_KEY_LOW    = 2'd1,
		CFG_KEY_HIGH   = 2'd2,
		CFG_MAX_NAMES  = 2'd3
	} cfg_reg_t;

	// result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_CHAR   = 2'd0,
		KIND_END    = 2'd1,
		KIND_FINISH = 2'd2
	} kind_t;

	// finish status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK         = 2'd0,
		ST_NO_KEY     = 2'd1,
		ST_NO_COLON   = 2'd2,
		ST_NO_BRACKET = 2'd3
	} status_t;

	// everything one byte produces: at most a character, an element end and
	// a finish, always in that order
	typedef struct packed {
		logic                has_char;
		logic                has_end;
		logic                has_finish;
		logic [BYTE_W-1:0]   chr;
		logic [POS_W-1:0]    char_pos;
		logic [POS_W-1:0]    end_pos;
		logic [CNT_W-1:0]    elem_count;
		status_t             status;
	} work_t;

	// queue status seen by the front and the back
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[rtl/json_string_array_extractor_core.sv]
// json_string_array_extractor_core: top level of the string array extractor.
// Instantiates jsae_front, jsae_queue and jsae_back; depends on jsae_pkg.
//
// Usage:
//   Document bytes enter on doc_valid/doc_ready with doc_byte and last_byte;
//   a zero byte or last_byte ends the document. Results leave on
//   result_valid/result_ready, one word per handshake: characters of each
//   array element, an element end word and one finish word with the status
//   and element count. last_result marks the final word caused by a byte.
//   Key and element limit are written on cfg_write/cfg_index/cfg_data, by
//   the user only while no document is in flight; not enforced by the block.
// Timing:
//   One byte per cycle. A taken byte is parsed and its work word queued at
//   once; the output register loads it once all results of the word before
//   have been handed out, and a byte holds the output for one handshake per
//   result. A four-entry work queue absorbs these bursts and receiver
//   stalls; the byte input stalls only when that queue is full.
// Reset:
//   arst_n clears the parse state, queue and output; registers return to
//   key length 0, key bytes 0 and element limit 64.
module json_string_array_extractor_core #(
	parameter int MAX_KEY_BYTES = 16,
	parameter int NAME_CAPACITY = 32,
	parameter int MAX_ELEMENTS  = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [jsae_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jsae_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           doc_valid,
	output logic                           doc_ready,
	input  logic [jsae_pkg::BYTE_W-1:0]    doc_byte,
	input  logic                           last_byte,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [jsae_pkg::KIND_W-1:0]    result_kind,
	output logic [jsae_pkg::IDX_W-1:0]     name_index,
	output logic [jsae_pkg::POS_W-1:0]     char_position,
	output logic [jsae_pkg::BYTE_W-1:0]    char_value,
	output logic [jsae_pkg::STAT_W-1:0]    finish_status,
	output logic [jsae_pkg::CNT_W-1:0]     name_count,
	output logic                           last_result
);
	import jsae_pkg::*;

	q_status_t q_stat;
	work_t     push_word;
	work_t     pop_word;
	logic      push;
	logic      pop;

	// byte parser
	jsae_front #(
		.MAX_KEY_BYTES(MAX_KEY_BYTES),
		.NAME_CAPACITY(NAME_CAPACITY),
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.doc_valid(doc_valid),
		.doc_ready(doc_ready),
		.doc_byte (doc_byte),
		.last_byte(last_byte),
		.q_stat   (q_stat),
		.push     (push),
		.work     (push_word)
	);

	// work queue
	jsae_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_word(push_word),
		.pop      (pop),
		.pop_word (pop_word),
		.q_stat   (q_stat)
	);

	// result output
	jsae_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_word     (pop_word),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.name_index   (name_index),
		.char_position(char_position),
		.char_value   (char_value),
		.finish_status(finish_status),
		.name_count   (name_count),
		.last_result  (last_result)
	);

endmodule

[rtl/jsae_front.sv]
// jsae_front: configuration registers, key window compare and parse phase.
// Turns each accepted byte into at most one work word for the queue.
// Depends on jsae_pkg.
module jsae_front #(
	parameter int MAX_KEY_BYTES = 16,
	parameter int NAME_CAPACITY = 32,
	parameter int MAX_ELEMENTS  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [jsae_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jsae_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                         doc_valid,
	output logic                         doc_ready,
	input  logic [jsae_pkg::BYTE_W-1:0]  doc_byte,
	input  logic                         last_byte,
	input  jsae_pkg::q_status_t          q_stat,
	output logic                         push,
	output jsae_pkg::work_t              work
);
	import jsae_pkg::*;

	localparam int CI_W     = (NAME_CAPACITY > 2) ? $clog2(NAME_CAPACITY) : 1;
	localparam int KLEN_CAP = (MAX_KEY_BYTES > 31) ? 31 : MAX_KEY_BYTES;
	localparam int LIM_CAP  = (MAX_ELEMENTS > 127) ? 127 : MAX_ELEMENTS;
	localparam int WIN_D    = MAX_KEY_BYTES + 1;
	localparam logic [CI_W-1:0] CI_LAST = CI_W'(NAME_CAPACITY - 1);

	typedef enum logic [8:0] {
		PH_SEARCH      = 9'b000000001,
		PH_AFTER_KEY   = 9'b000000010,
		PH_AFTER_COLON = 9'b000000100,
		PH_IN_ARRAY    = 9'b000001000,
		PH_IN_NAME     = 9'b000010000,
		PH_NAME_ESC    = 9'b000100000,
		PH_DISCARD     = 9'b001000000,
		PH_DISCARD_ESC = 9'b010000000,
		PH_DONE        = 9'b100000000
	} phase_t;

	// configuration registers
	logic [KEY_LEN_W-1:0]  key_length_q;
	logic [KEY_WORD_W-1:0] key_low_q;
	logic [KEY_WORD_W-1:0] key_high_q;
	logic [CNT_W-1:0]      max_names_q;

	// parse state
	phase_t             phase_q;
	logic [CNT_W-1:0]   ec_q;
	logic [CI_W-1:0]    ci_q;
	logic [BYTE_W-1:0]  window_q [WIN_D];

	logic                doc_fire;
	logic                byte_zero;
	logic                end_doc;
	logic [KEY_LEN_W-1:0] klen;
	logic [CNT_W-1:0]    lim;
	logic [2*KEY_WORD_W-1:0] key_vec;
	logic                key_hit;

	phase_t             ph_n;
	logic [CNT_W-1:0]   ec_n;
	logic [CI_W-1:0]    ci_n;
	logic               put_req;
	logic               end_req;
	logic               cap_end;

	function automatic logic is_ws(input logic [BYTE_W-1:0] b);
		return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
	endfunction

	assign doc_ready = !q_stat.full;
	assign doc_fire  = doc_valid && doc_ready;
	assign byte_zero = (doc_byte == CH_NUL);
	assign end_doc   = byte_zero || last_byte;
	assign push      = doc_fire && (work.has_char || work.has_end || work.has_finish);

	// clamped key length and element limit
	assign klen = (key_length_q > KEY_LEN_W'(KLEN_CAP)) ? KEY_LEN_W'(KLEN_CAP) : key_length_q;
	assign lim  = (max_names_q > CNT_W'(LIM_CAP)) ? CNT_W'(LIM_CAP) : max_names_q;
	assign key_vec = {key_high_q, key_low_q};

	// window compare: newest byte is the closing quote, oldest used tap the
	// opening quote, key bytes in between from newest to oldest
	always_comb begin
		logic [6:0]        pos7;
		logic [6:0]        klen7;
		logic [6:0]        kj;
		logic [BYTE_W-1:0] want;
		key_hit = (doc_byte == CH_QUOTE);
		klen7   = 7'(klen);
		for (int p = 0; p < WIN_D; p++) begin
			pos7 = 7'(p);
			kj   = klen7 - 7'd1 - pos7;
			want = CH_QUOTE;
			if (pos7 < klen7) begin
				want = (kj < 7'd16) ? key_vec[{kj[3:0], 3'b000} +: BYTE_W] : CH_NUL;
			end
			if ((pos7 <= klen7) && (window_q[p] != want)) begin
				key_hit = 1'b0;
			end
		end
	end

	// next state and work word for the current byte
	always_comb begin
		ph_n    = phase_q;
		ec_n    = ec_q;
		ci_n    = ci_q;
		put_req = 1'b0;
		end_req = 1'b0;
		cap_end = 1'b0;
		work    = '0;
		work.elem_count = ec_q;
		if (phase_q != PH_DONE) begin
			// byte itself
			if (!byte_zero) begin
				case (phase_q)
					PH_SEARCH: begin
						if (key_hit) ph_n = PH_AFTER_KEY;
					end
					PH_AFTER_KEY: begin
						if (doc_byte == CH_COLON) begin
							ph_n = PH_AFTER_COLON;
						end else if (!is_ws(doc_byte)) begin
							work.has_finish = 1'b1;
							work.status     = ST_NO_COLON;
							ph_n            = PH_DONE;
						end
					end
					PH_AFTER_COLON: begin
						if (doc_byte == CH_LBRACK) begin
							if (ec_q >= lim) begin
								work.has_finish = 1'b1;
								work.status     = ST_OK;
								ph_n            = PH_DONE;
							end else begin
								ph_n = PH_IN_ARRAY;
							end
						end else if (!is_ws(doc_byte)) begin
							work.has_finish = 1'b1;
							work.status     = ST_NO_BRACKET;
							ph_n            = PH_DONE;
						end
					end
					PH_IN_ARRAY: begin
						if (doc_byte == CH_RBRACK) begin
							work.has_finish = 1'b1;
							work.status     = ST_OK;
							ph_n            = PH_DONE;
						end else if (doc_byte == CH_QUOTE) begin
							ph_n = PH_IN_NAME;
							ci_n = '0;
						end
					end
					PH_IN_NAME: begin
						if (doc_byte == CH_QUOTE) begin
							end_req = 1'b1;
						end else if (doc_byte == CH_BSLASH) begin
							ph_n = PH_NAME_ESC;
						end else begin
							put_req  = 1'b1;
							work.chr = doc_byte;
						end
					end
					PH_NAME_ESC: begin
						put_req  = 1'b1;
						work.chr = doc_byte;
					end
					PH_DISCARD: begin
						if (doc_byte == CH_BSLASH) ph_n = PH_DISCARD_ESC;
						else if (doc_byte == CH_QUOTE) ph_n = PH_IN_ARRAY;
					end
					default: begin
						ph_n = PH_DISCARD;
					end
				endcase
			end
			// dangling backslash at document end is itself a character
			if (end_doc && (ph_n == PH_NAME_ESC) && !put_req) begin
				put_req  = 1'b1;
				work.chr = CH_BSLASH;
			end
			// character output, ending the element when full
			if (put_req) begin
				work.has_char = 1'b1;
				work.char_pos = POS_W'(ci_n);
				ci_n          = ci_n + CI_W'(1);
				ph_n          = PH_IN_NAME;
				if (ci_n >= CI_LAST) begin
					end_req = 1'b1;
					cap_end = 1'b1;
				end
			end
			// document end closes an open element
			if (end_doc && (ph_n == PH_IN_NAME)) begin
				end_req = 1'b1;
			end
			// element end
			if (end_req) begin
				work.has_end = 1'b1;
				work.end_pos = POS_W'(ci_n);
				ec_n         = ec_n + CNT_W'(1);
				if (ec_n >= lim) begin
					work.has_finish = 1'b1;
					work.status     = ST_OK;
					ph_n            = PH_DONE;
				end else begin
					ph_n = cap_end ? PH_DISCARD : PH_IN_ARRAY;
				end
			end
			// finish at document end
			if (end_doc && !work.has_finish) begin
				work.has_finish = 1'b1;
				case (ph_n)
					PH_SEARCH:      work.status = ST_NO_KEY;
					PH_AFTER_KEY:   work.status = ST_NO_COLON;
					PH_AFTER_COLON: work.status = ST_NO_BRACKET;
					default:        work.status = ST_OK;
				endcase
				ph_n = PH_DONE;
			end
		end
		// every document end starts a fresh document
		if (end_doc) begin
			ph_n = PH_SEARCH;
			ec_n = '0;
			ci_n = '0;
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_length_q <= '0;
			key_low_q    <= '0;
			key_high_q   <= '0;
			max_names_q  <= MAX_NAMES_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KEY_LENGTH: key_length_q <= cfg_data[KEY_LEN_W-1:0];
				CFG_KEY_LOW:    key_low_q    <= cfg_data[KEY_WORD_W-1:0];
				CFG_KEY_HIGH:   key_high_q   <= cfg_data[KEY_WORD_W-1:0];
				CFG_MAX_NAMES:  max_names_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			ec_q    <= '0;
			ci_q    <= '0;
		end else if (doc_fire) begin
			phase_q <= ph_n;
			ec_q    <= ec_n;
			ci_q    <= ci_n;
		end
	end

	// key window shifts only while searching
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_D; i++) window_q[i] <= '0;
		end else if (doc_fire) begin
			if (end_doc) begin
				for (int i = 0; i < WIN_D; i++) window_q[i] <= '0;
			end else if (phase_q == PH_SEARCH) begin
				for (int i = WIN_D - 1; i > 0; i--) window_q[i] <= window_q[i-1];
				window_q[0] <= doc_byte;
			end
		end
	end

	// a character is only taken while the element has room
	a_char_room: assert property (@(posedge clk) disable iff (!arst_n)
		doc_fire && work.has_char && (phase_q == PH_IN_NAME || phase_q == PH_NAME_ESC)
			|-> ci_q < CI_LAST)
		else $error("character taken with element already full");

	// an element end that does not finish leaves the parser between elements or skipping a cut element
	a_end_phase: assert property (@(posedge clk) disable iff (!arst_n)
		doc_fire && work.has_end && !work.has_finish && !end_doc
			|=> (phase_q == PH_IN_ARRAY || phase_q == PH_DISCARD))
		else $error("element end left parser in wrong phase");

endmodule

[rtl/jsae_queue.sv]
// jsae_queue: short work word queue between front and back.
// Lets the front keep taking bytes while the back waits on the receiver.
// Depends on jsae_pkg.
module jsae_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  jsae_pkg::work_t     push_word,
	input  logic                pop,
	output jsae_pkg::work_t     pop_word,
	output jsae_pkg::q_status_t q_stat
);
	import jsae_pkg::*;

	work_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_word     = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_word;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> !q_stat.full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue read while empty");

endmodule

[rtl/jsae_back.sv]
// jsae_back: unpacks work words into single results, one word per handshake.
// Holds one work word and a mask of the results still owed from it.
// Depends on jsae_pkg.
module jsae_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  jsae_pkg::q_status_t         q_stat,
	input  jsae_pkg::work_t             pop_word,
	output logic                        pop,
	output logic                        result_valid,
	input  logic                        result_ready,
	output logic [jsae_pkg::KIND_W-1:0] result_kind,
	output logic [jsae_pkg::IDX_W-1:0]  name_index,
	output logic [jsae_pkg::POS_W-1:0]  char_position,
	output logic [jsae_pkg::BYTE_W-1:0] char_value,
	output logic [jsae_pkg::STAT_W-1:0] finish_status,
	output logic [jsae_pkg::CNT_W-1:0]  name_count,
	output logic                        last_result
);
	import jsae_pkg::*;

	// pending mask: bit 0 character, bit 1 element end, bit 2 finish
	work_t       word_q;
	logic [2:0]  pend_q;
	logic [2:0]  pend_rest;
	logic        take;
	logic        load;

	assign result_valid = |pend_q;
	assign pend_rest    = pend_q & (pend_q - 3'd1);
	assign last_result  = (pend_rest == 3'b000);
	assign take         = result_valid && result_ready;
	assign load         = (!result_valid || (take && last_result)) && !q_stat.empty;
	assign pop          = load;

	// present the oldest owed result
	always_comb begin
		result_kind   = KIND_FINISH;
		name_index    = '0;
		char_position = '0;
		char_value    = '0;
		finish_status = word_q.status;
		name_count    = word_q.elem_count + CNT_W'(word_q.has_end);
		if (pend_q[0]) begin
			result_kind   = KIND_CHAR;
			name_index    = word_q.elem_count[IDX_W-1:0];
			char_position = word_q.char_pos;
			char_value    = word_q.chr;
			finish_status = ST_OK;
			name_count    = word_q.elem_count;
		end else if (pend_q[1]) begin
			result_kind   = KIND_END;
			name_index    = word_q.elem_count[IDX_W-1:0];
			char_position = word_q.end_pos;
			finish_status = ST_OK;
			name_count    = word_q.elem_count + CNT_W'(1);
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (load) word_q <= pop_word;
	end

	// owed results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (load) begin
			pend_q <= {pop_word.has_finish, pop_word.has_end, pop_word.has_char};
		end else if (take) begin
			pend_q <= pend_rest;
		end
	end

	// a finish always closes the results of its byte
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_kind == KIND_FINISH) |-> last_result)
		else $error("finish result not marked last");

endmodule

[dv/tb.sv]
// tb.sv: self-checking testbench for json_string_array_extractor_core, with an
// expected-word scoreboard class, document generators and byte/config drivers.
// Depends on jsae_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
	import jsae_pkg::*;

	localparam int KEY_SLOTS    = 16;
	localparam int NAME_CAP     = 32;
	localparam int ELEM_MAX     = 64;
	localparam int DRAIN_CYCLES = 16;
	localparam int IDLE_LIMIT   = 20000;
	localparam int PHASE_BYTES  = 32;
	localparam int REPORT_CAP   = 20;

	localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
	localparam logic [BYTE_W-1:0] CH_ONES    = 8'hFF;

	typedef enum int {
		SEEK_KEY, WANT_COLON, WANT_BRACKET, BETWEEN, IN_ELEM, ELEM_ESC,
		SKIP_ELEM, SKIP_ESC, FINISHED
	} scan_phase_e;

	typedef enum int {FILL_LETTERS, FILL_ONES, FILL_WITH_NUL} key_fill_e;

	typedef struct {
		kind_t             kind;
		logic [IDX_W-1:0]  idx;
		logic [POS_W-1:0]  pos;
		logic [BYTE_W-1:0] chr;
		status_t           status;
		logic [CNT_W-1:0]  count;
		logic              last;
	} result_word_t;

	// expected-word store and its own copy of the extractor state
	class extract_scoreboard;
		logic [BYTE_W-1:0]     window [KEY_SLOTS+1];
		scan_phase_e           phase;
		int unsigned           elems;
		int unsigned           pos;
		logic [KEY_LEN_W-1:0]  key_len;
		logic [KEY_WORD_W-1:0] key_lo;
		logic [KEY_WORD_W-1:0] key_hi;
		logic [CNT_W-1:0]      name_limit;
		result_word_t          expected_words[$];
		int unsigned           step_words;
		int                    errors;
		int                    words_checked;
		int                    finishes;
		int                    elements_seen;
		int                    bytes_worked;

		function new();
			key_len = '0;
			key_lo = '0;
			key_hi = '0;
			name_limit = MAX_NAMES_RESET;
			errors = 0;
			words_checked = 0;
			finishes = 0;
			elements_seen = 0;
			bytes_worked = 0;
			restart();
		endfunction

		function void restart();
			foreach (window[i]) window[i] = '0;
			phase = SEEK_KEY;
			elems = 0;
			pos = 0;
		endfunction

		function void write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] data);
			case (which)
				CFG_KEY_LENGTH: key_len = data[KEY_LEN_W-1:0];
				CFG_KEY_LOW:    key_lo = data;
				CFG_KEY_HIGH:   key_hi = data;
				default:        name_limit = data[CNT_W-1:0];
			endcase
		endfunction

		function int unsigned pending();
			return expected_words.size();
		endfunction

		function void report(string what);
			errors++;
			if (errors <= REPORT_CAP)
				$display("[%0t] mismatch: %s", $realtime, what);
		endfunction

		function void emit(kind_t kind, int unsigned idx, int unsigned at,
				logic [BYTE_W-1:0] chr, status_t status);
			result_word_t w;
			w.kind = kind;
			w.idx = IDX_W'(idx);
			w.pos = POS_W'(at);
			w.chr = chr;
			w.status = status;
			w.count = CNT_W'(elems);
			w.last = 1'b0;
			expected_words.push_back(w);
			step_words++;
		endfunction

		function int unsigned limit();
			return (name_limit > ELEM_MAX) ? ELEM_MAX : name_limit;
		endfunction

		function void finish(status_t status);
			emit(KIND_FINISH, 0, 0, CH_NUL, status);
			phase = FINISHED;
			finishes++;
		endfunction

		function void end_elem();
			int unsigned idx;
			idx = elems;
			elems++;
			elements_seen++;
			emit(KIND_END, idx, pos, CH_NUL, ST_OK);
			if (elems >= limit())
				finish(ST_OK);
			else
				phase = BETWEEN;
		endfunction

		// a full element is cut off and the rest skipped to its closing quote
		function void put_char(logic [BYTE_W-1:0] c);
			emit(KIND_CHAR, elems, pos, c, ST_OK);
			pos++;
			phase = IN_ELEM;
			if (pos >= NAME_CAP - 1) begin
				end_elem();
				if (phase != FINISHED)
					phase = SKIP_ELEM;
			end
		endfunction

		function logic [BYTE_W-1:0] key_byte(int unsigned j);
			if (j < 8)
				return key_lo[8*j +: 8];
			return key_hi[8*(j-8) +: 8];
		endfunction

		// quoted key ending at the incoming byte
		function bit key_hit(logic [BYTE_W-1:0] b);
			int unsigned span;
			int unsigned k;
			logic [BYTE_W-1:0] got;
			logic [BYTE_W-1:0] want;
			span = ((key_len > KEY_SLOTS) ? KEY_SLOTS : key_len) + 2;
			for (int unsigned j = 0; j < span; j++) begin
				k = span - 1 - j;
				got = (k == 0) ? b : window[k-1];
				want = (j == 0 || j == span - 1) ? CH_QUOTE : key_byte(j - 1);
				if (got != want)
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function bit is_space(logic [BYTE_W-1:0] b);
			return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
		endfunction

		// expected words for one accepted document byte
		function void note_byte(logic [BYTE_W-1:0] b, logic fin);
			bit ends;
			result_word_t w;
			ends = (b == CH_NUL) || fin;
			step_words = 0;
			if (phase == FINISHED) begin
				if (ends)
					restart();
				return;
			end
			bytes_worked++;
			if (b != CH_NUL) begin
				case (phase)
					SEEK_KEY: begin
						if (key_hit(b))
							phase = WANT_COLON;
						for (int i = KEY_SLOTS; i > 0; i--)
							window[i] = window[i-1];
						window[0] = b;
					end
					WANT_COLON: begin
						if (b == CH_COLON)
							phase = WANT_BRACKET;
						else if (!is_space(b))
							finish(ST_NO_COLON);
					end
					WANT_BRACKET: begin
						if (b == CH_LBRACK) begin
							if (elems >= limit())
								finish(ST_OK);
							else
								phase = BETWEEN;
						end else if (!is_space(b)) begin
							finish(ST_NO_BRACKET);
						end
					end
					BETWEEN: begin
						if (b == CH_RBRACK) begin
							finish(ST_OK);
						end else if (b == CH_QUOTE) begin
							phase = IN_ELEM;
							pos = 0;
						end
					end
					IN_ELEM: begin
						if (b == CH_QUOTE)
							end_elem();
						else if (b == CH_BSLASH)
							phase = ELEM_ESC;
						else
							put_char(b);
					end
					ELEM_ESC: put_char(b);
					SKIP_ELEM: begin
						if (b == CH_BSLASH)
							phase = SKIP_ESC;
						else if (b == CH_QUOTE)
							phase = BETWEEN;
					end
					default: phase = SKIP_ELEM;
				endcase
			end
			// document end closes whatever is open
			if (ends) begin
				if (phase == ELEM_ESC)
					put_char(CH_BSLASH);
				case (phase)
					SEEK_KEY:     finish(ST_NO_KEY);
					WANT_COLON:   finish(ST_NO_COLON);
					WANT_BRACKET: finish(ST_NO_BRACKET);
					IN_ELEM: begin
						end_elem();
						if (phase != FINISHED)
							finish(ST_OK);
					end
					FINISHED: ;
					default: finish(ST_OK);
				endcase
				restart();
			end
			if (step_words > 0) begin
				w = expected_words.pop_back();
				w.last = 1'b1;
				expected_words.push_back(w);
			end
		endfunction

		function void compare_field(string field, logic [BYTE_W-1:0] got,
				logic [BYTE_W-1:0] want);
			if (got !== want)
				report($sformatf("word %0d %s got %0h expected %0h",
					words_checked, field, got, want));
		endfunction

		function void check_result(result_word_t got);
			result_word_t want;
			if (expected_words.size() == 0) begin
				report($sformatf("word of kind %0d with nothing expected", got.kind));
				return;
			end
			want = expected_words.pop_front();
			compare_field("result_kind", BYTE_W'(got.kind), BYTE_W'(want.kind));
			compare_field("name_index", BYTE_W'(got.idx), BYTE_W'(want.idx));
			compare_field("char_position", BYTE_W'(got.pos), BYTE_W'(want.pos));
			compare_field("char_value", got.chr, want.chr);
			compare_field("finish_status", BYTE_W'(got.status), BYTE_W'(want.status));
			compare_field("name_count", BYTE_W'(got.count), BYTE_W'(want.count));
			compare_field("last_result", BYTE_W'(got.last), BYTE_W'(want.last));
			words_checked++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  doc_valid;
	logic                  doc_ready;
	logic [BYTE_W-1:0]     doc_byte;
	logic                  last_byte;
	logic                  result_valid;
	logic                  result_ready;
	logic [KIND_W-1:0]     result_kind;
	logic [IDX_W-1:0]      name_index;
	logic [POS_W-1:0]      char_position;
	logic [BYTE_W-1:0]     char_value;
	logic [STAT_W-1:0]     finish_status;
	logic [CNT_W-1:0]      name_count;
	logic                  last_result;

	extract_scoreboard sb;
	result_word_t      seen_word;
	logic [BYTE_W-1:0] doc_text[$];
	logic [BYTE_W-1:0] key_text[KEY_SLOTS];
	int                key_used;
	int                bytes_sent;
	bit                no_gaps;

	json_string_array_extractor_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.doc_valid     (doc_valid),
		.doc_ready     (doc_ready),
		.doc_byte      (doc_byte),
		.last_byte     (last_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_kind   (result_kind),
		.name_index    (name_index),
		.char_position (char_position),
		.char_value    (char_value),
		.finish_status (finish_status),
		.name_count    (name_count),
		.last_result   (last_result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver stalls
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			int hold;
			result_ready = 1'b1;
			repeat (($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 12))
				@(negedge clk);
			hold = pick_gap();
			if (hold > 0) begin
				result_ready = 1'b0;
				repeat (hold) @(negedge clk);
			end
		end
	end

	// result word monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			seen_word.kind = kind_t'(result_kind);
			seen_word.idx = name_index;
			seen_word.pos = char_position;
			seen_word.chr = char_value;
			seen_word.status = status_t'(finish_status);
			seen_word.count = name_count;
			seen_word.last = last_result;
			sb.check_result(seen_word);
		end
	end

	// one document byte, entered and left at a falling edge
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic fin);
		int hold;
		doc_valid = 1'b1;
		doc_byte = b;
		last_byte = fin;
		@(posedge clk);
		while (!doc_ready) @(posedge clk);
		sb.note_byte(b, fin);
		bytes_sent++;
		@(negedge clk);
		hold = no_gaps ? 0 : pick_gap();
		if (hold > 0) begin
			doc_valid = 1'b0;
			repeat (hold) @(negedge clk);
		end
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_byte(text[i], i == text.len() - 1);
	endtask

	task automatic send_doc();
		bit mark_last;
		mark_last = 1'($urandom_range(0, 1));
		for (int i = 0; i < doc_text.size(); i++)
			send_byte(doc_text[i], mark_last && (i == doc_text.size() - 1));
		if (!mark_last)
			send_byte(CH_NUL, 1'($urandom_range(0, 1)));
	endtask

	// wait for all expected words, then let the block settle
	task automatic wait_idle();
		int waited;
		doc_valid = 1'b0;
		waited = 0;
		while (sb.pending() != 0 && waited < IDLE_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (sb.pending() != 0)
			sb.report($sformatf("%0d words never arrived", sb.pending()));
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] data);
		cfg_write = 1'b1;
		cfg_index = which;
		cfg_data = data;
		sb.write_reg(which, data);
		@(negedge clk);
	endtask

	// key text and all four registers; unused upper bits get random values
	task automatic set_config(input int len_field, input key_fill_e fill,
			input int limit_field);
		logic [CFG_DATA_W-1:0] lo;
		logic [CFG_DATA_W-1:0] hi;
		key_used = (len_field > KEY_SLOTS) ? KEY_SLOTS : len_field;
		for (int i = 0; i < KEY_SLOTS; i++)
			key_text[i] = (fill == FILL_ONES) ? CH_ONES :
				BYTE_W'(CH_LOWER_A + $urandom_range(0, 25));
		if (fill == FILL_WITH_NUL && key_used > 0)
			key_text[$urandom_range(0, key_used - 1)] = CH_NUL;
		for (int i = 0; i < 8; i++) begin
			lo[8*i +: 8] = key_text[i];
			hi[8*i +: 8] = key_text[i+8];
		end
		write_reg(CFG_KEY_LENGTH, {$urandom, 27'($urandom), 5'(len_field)});
		write_reg(CFG_KEY_LOW, lo);
		write_reg(CFG_KEY_HIGH, hi);
		write_reg(CFG_MAX_NAMES, {$urandom, 25'($urandom), 7'(limit_field)});
		cfg_write = 1'b0;
	endtask

	function automatic logic [BYTE_W-1:0] pick_space();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_LF;
			default: return CH_CR;
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] noise_char();
		case ($urandom_range(0, 5))
			0: return pick_space();
			1: return CH_COMMA;
			2: return CH_QUOTE;
			default: return BYTE_W'(CH_LOWER_A + $urandom_range(0, 25));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] plain_char();
		logic [BYTE_W-1:0] c;
		if ($urandom_range(0, 9) < 7)
			return BYTE_W'(CH_LOWER_A + $urandom_range(0, 25));
		do
			c = BYTE_W'($urandom_range(1, 255));
		while (c == CH_QUOTE || c == CH_BSLASH);
		return c;
	endfunction

	// one document: mostly key, colon, bracket and elements with random content;
	// the rest noise, a missing colon or bracket, or a cut-off document
	function automatic void build_doc();
		int shape;
		int n_elem;
		int len;
		int cut;
		doc_text.delete();
		shape = $urandom_range(0, 99);
		if (shape < 15) begin
			repeat ($urandom_range(1, 10))
				doc_text.push_back(($urandom_range(0, 15) == 0) ? CH_NUL :
					BYTE_W'($urandom_range(1, 255)));
			return;
		end
		repeat ($urandom_range(0, 4)) doc_text.push_back(noise_char());
		doc_text.push_back(CH_QUOTE);
		for (int i = 0; i < key_used; i++)
			doc_text.push_back(key_text[i]);
		doc_text.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 2)) doc_text.push_back(pick_space());
		if (shape < 22) begin
			doc_text.push_back(BYTE_W'(CH_LOWER_A + $urandom_range(0, 25)));
		end else begin
			doc_text.push_back(CH_COLON);
			repeat ($urandom_range(0, 2)) doc_text.push_back(pick_space());
			if (shape < 29) begin
				doc_text.push_back(($urandom_range(0, 1) == 0) ? CH_RBRACK : CH_QUOTE);
			end else begin
				doc_text.push_back(CH_LBRACK);
				n_elem = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
				for (int e = 0; e < n_elem; e++) begin
					if (e > 0)
						doc_text.push_back(CH_COMMA);
					if ($urandom_range(0, 3) == 0)
						doc_text.push_back(noise_char() == CH_QUOTE ? CH_SPACE : pick_space());
					doc_text.push_back(CH_QUOTE);
					len = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 36) : $urandom_range(0, 6);
					for (int c = 0; c < len; c++) begin
						if ($urandom_range(0, 99) < 15) begin
							doc_text.push_back(CH_BSLASH);
							doc_text.push_back(BYTE_W'($urandom_range(1, 255)));
						end else begin
							doc_text.push_back(plain_char());
						end
					end
					doc_text.push_back(CH_QUOTE);
				end
				repeat ($urandom_range(0, 1)) doc_text.push_back(pick_space());
				doc_text.push_back(CH_RBRACK);
			end
		end
		repeat ($urandom_range(0, 3)) doc_text.push_back(noise_char());
		if ($urandom_range(0, 9) == 0) begin
			cut = $urandom_range(1, doc_text.size());
			while (doc_text.size() > cut)
				void'(doc_text.pop_back());
		end
	endfunction

	task automatic run_phase(input int len_field, input key_fill_e fill,
			input int limit_field);
		int start;
		wait_idle();
		set_config(len_field, fill, limit_field);
		start = bytes_sent;
		while (bytes_sent - start < PHASE_BYTES) begin
			build_doc();
			send_doc();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_KEY_LENGTH;
		cfg_data = '0;
		doc_valid = 1'b0;
		doc_byte = CH_NUL;
		last_byte = 1'b0;
		bytes_sent = 0;
		no_gaps = 1'b0;
		key_used = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, so the key is an empty quoted string
		send_text("\"\":[\"a\\\"\"]");
		send_byte(CH_ONES, 1'b0);
		send_byte(CH_NUL, 1'b0);
		send_text("\"\":[\"\\");
		send_text("\"\"x");
		send_text("\"\":x");

		// random documents over several key and element limit settings
		run_phase(16, FILL_LETTERS, 1);
		run_phase(31, FILL_ONES, 127);
		run_phase(0, FILL_LETTERS, 0);
		run_phase($urandom_range(1, 6), FILL_LETTERS, 2);
		run_phase(3, FILL_WITH_NUL, 64);
		run_phase($urandom_range(1, 15), FILL_LETTERS, $urandom_range(65, 126));
		run_phase($urandom_range(1, 8), FILL_LETTERS, $urandom_range(3, 64));
		no_gaps = 1'b1;
		run_phase($urandom_range(1, 4), FILL_LETTERS, 64);
		wait_idle();

		$display("sent %0d document bytes (%0d parsed), checked %0d result words",
			bytes_sent, sb.bytes_worked, sb.words_checked);
		$display("covered %0d array elements and %0d finishes over 9 settings",
			sb.elements_seen, sb.finishes);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
rtl/jsae_pkg.sv
rtl/jsae_front.sv
rtl/jsae_queue.sv
rtl/jsae_back.sv
rtl/json_string_array_extractor_core.sv
dv/tb.sv
